/* rtl/core/lps_pkg.sv */
package lps_pkg;

    localparam int MAX_LEDS = 64;
    localparam int IDX_W    = $clog2(MAX_LEDS);
    localparam int COUNT_W  = 7;
    localparam int CH_W     = 8;
    localparam int WORD_W   = 3 * CH_W;
    localparam int PROD_W   = 2 * CH_W;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [COUNT_W-1:0] MAX_COUNT        = COUNT_W'(MAX_LEDS);
    localparam logic [CH_W-1:0]    BRIGHTNESS_RESET = 8'hff;
    localparam logic [COUNT_W-1:0] LED_COUNT_RESET  = COUNT_W'(MAX_LEDS);

    // register select is paddr[2]
    localparam logic REG_BRIGHTNESS = 1'b0;
    localparam logic REG_LED_COUNT  = 1'b1;

    typedef enum logic
    {
        ACT_WRITE = 1'b0,
        ACT_SHOW  = 1'b1
    } action_t;

    typedef struct packed
    {
        action_t                 op;
        logic [IDX_W-1:0]        idx;
        logic [WORD_W-1:0]       rgb;
    } cmd_t;

    function automatic logic [COUNT_W-1:0] active_count(input logic [COUNT_W-1:0] led_count);
        return (led_count > MAX_COUNT) ? MAX_COUNT : led_count;
    endfunction

    // floor(p / 255) for p up to 255*255
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] t;
        t = {1'b0, p} + {{(CH_W+1){1'b0}}, p[PROD_W-1:CH_W]} + (PROD_W+1)'(1);
        return t[PROD_W-1:CH_W];
    endfunction

endpackage

/* rtl/core/lps_in_if.sv */
interface lps_in_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [7:0]                   pixel_index;
    logic [lps_pkg::CH_W-1:0]     red;
    logic [lps_pkg::CH_W-1:0]     green;
    logic [lps_pkg::CH_W-1:0]     blue;

    modport source (output valid, action, pixel_index, red, green, blue, input ready);
    modport sink   (input valid, action, pixel_index, red, green, blue, output ready);
endinterface

/* rtl/core/lps_out_if.sv */
interface lps_out_if;
    logic                         valid;
    logic                         ready;
    logic [lps_pkg::WORD_W-1:0]   color_word;
    logic [lps_pkg::IDX_W-1:0]    pixel_position;
    logic                         last_pixel;

    modport source (output valid, color_word, pixel_position, last_pixel, input ready);
    modport sink   (input valid, color_word, pixel_position, last_pixel, output ready);
endinterface

/* rtl/core/led_pixel_store_with_brightness_unit.sv */
// Pixel store for an addressable LED chain with a global brightness factor.
// Input channel pixel_in carries one item per handshake (valid & ready):
// a write item (action 0) stores unscaled red/green/blue at pixel_index,
// a show item (action 1) streams the whole chain out on pixel_out.
// Writes at or above the active LED count, and shows of an empty chain,
// are accepted and dropped. The active count is led_count capped at 64.
// Each result item carries the scaled word, floor(c*brightness/255) per
// channel, its LED position, and last_pixel on the final word of a show.
// Items pass through a two-deep command queue; input stays ready while
// the queue has room, so it keeps accepting while a show is drained.
// With the back end idle, an accepted show passes the queue entry and the
// walk cursor, then the read, scale and output registers, before its first
// word is presented; then one word per cycle while the receiver is ready.
// The back end takes no queued item while a show walks the memory read port.
// When the receiver stalls, the read/scale pipeline freezes in place and
// resumes without loss. Reset clears the store (per-entry written flags),
// sets brightness to 255 and led_count to 64. APB registers: brightness at
// byte address 0, led_count at 4; write them only while the block is idle.
module led_pixel_store_with_brightness_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lps_pkg::PADDR_W-1:0]  paddr,
    input  logic [lps_pkg::PDATA_W-1:0]  pwdata,
    output logic [lps_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    lps_in_if.sink                       pixel_in,
    lps_out_if.source                    pixel_out
);

    logic [lps_pkg::CH_W-1:0]    brightness_reg;
    logic [lps_pkg::COUNT_W-1:0] led_count_reg;
    logic [lps_pkg::COUNT_W-1:0] count;
    logic                        cfg_wr;

    logic                        push_valid;
    logic                        push_ready;
    lps_pkg::cmd_t               push_cmd;
    logic                        pop_valid;
    logic                        pop_ready;
    lps_pkg::cmd_t               pop_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register writes land in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= lps_pkg::BRIGHTNESS_RESET;
            led_count_reg  <= lps_pkg::LED_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                lps_pkg::REG_BRIGHTNESS: brightness_reg <= pwdata[lps_pkg::CH_W-1:0];
                lps_pkg::REG_LED_COUNT:  led_count_reg  <= pwdata[lps_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            lps_pkg::REG_BRIGHTNESS:
                prdata = {{(lps_pkg::PDATA_W-lps_pkg::CH_W){1'b0}}, brightness_reg};
            lps_pkg::REG_LED_COUNT:
                prdata = {{(lps_pkg::PDATA_W-lps_pkg::COUNT_W){1'b0}}, led_count_reg};
            default:
                prdata = '0;
        endcase
    end

    // count above the store depth saturates
    assign count = lps_pkg::active_count(led_count_reg);

    lps_front u_front
    (
        .pixel_in   (pixel_in),
        .count      (count),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    lps_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    lps_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .count      (count),
        .brightness (brightness_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .pixel_out  (pixel_out)
    );

endmodule

/* rtl/core/lps_queue.sv */
module lps_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  lps_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output lps_pkg::cmd_t pop_cmd
);

    lps_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    fill_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

/* rtl/core/lps_front.sv */
module lps_front
(
    lps_in_if.sink                       pixel_in,
    input  logic [lps_pkg::COUNT_W-1:0]  count,
    output logic                         push_valid,
    input  logic                         push_ready,
    output lps_pkg::cmd_t                push_cmd
);

    logic keep;

    // drop writes past the chain and shows of an empty chain
    always_comb
    begin
        if (lps_pkg::action_t'(pixel_in.action) == lps_pkg::ACT_SHOW)
        begin
            keep = (count != '0);
        end
        else
        begin
            keep = ({1'b0, pixel_in.pixel_index} < {2'b0, count});
        end
    end

    assign pixel_in.ready = push_ready;
    assign push_valid     = pixel_in.valid && keep;
    assign push_cmd.op    = lps_pkg::action_t'(pixel_in.action);
    assign push_cmd.idx   = pixel_in.pixel_index[lps_pkg::IDX_W-1:0];
    assign push_cmd.rgb   = {pixel_in.red, pixel_in.green, pixel_in.blue};

endmodule

/* rtl/core/lps_back.sv */
module lps_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lps_pkg::COUNT_W-1:0]  count,
    input  logic [lps_pkg::CH_W-1:0]     brightness,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  lps_pkg::cmd_t                pop_cmd,
    lps_out_if.source                    pixel_out
);

    logic [lps_pkg::WORD_W-1:0]  mem [lps_pkg::MAX_LEDS];
    logic [lps_pkg::MAX_LEDS-1:0] written_reg;

    logic                        walking_reg;
    logic [lps_pkg::IDX_W-1:0]   cursor_reg;

    logic                        s1_valid_reg;
    logic [lps_pkg::IDX_W-1:0]   s1_pos_reg;
    logic                        s1_last_reg;
    logic [lps_pkg::WORD_W-1:0]  rd_word_reg;
    logic                        rd_ok_reg;

    logic                        s2_valid_reg;
    logic [lps_pkg::IDX_W-1:0]   s2_pos_reg;
    logic                        s2_last_reg;
    logic [lps_pkg::PROD_W-1:0]  prod_r_reg;
    logic [lps_pkg::PROD_W-1:0]  prod_g_reg;
    logic [lps_pkg::PROD_W-1:0]  prod_b_reg;

    logic                        out_valid_reg;
    logic [lps_pkg::WORD_W-1:0]  out_word_reg;
    logic [lps_pkg::IDX_W-1:0]   out_pos_reg;
    logic                        out_last_reg;

    logic                        adv;
    logic                        issue;
    logic                        cursor_last;
    logic                        take;
    logic                        wr_en;
    logic [lps_pkg::WORD_W-1:0]  pix;

    assign adv         = !out_valid_reg || pixel_out.ready;
    assign issue       = walking_reg && adv;
    assign cursor_last = (({1'b0, cursor_reg} + lps_pkg::COUNT_W'(1)) == count);
    assign pop_ready   = !walking_reg;
    assign take        = pop_valid && pop_ready;
    assign wr_en       = take && (pop_cmd.op == lps_pkg::ACT_WRITE);
    assign pix         = rd_ok_reg ? rd_word_reg : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pop_cmd.idx] <= pop_cmd.rgb;
        end
        if (issue)
        begin
            rd_word_reg <= mem[cursor_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pos_reg   <= cursor_reg;
            s1_last_reg  <= cursor_last;
            s2_pos_reg   <= s1_pos_reg;
            s2_last_reg  <= s1_last_reg;
            prod_r_reg   <= pix[23:16] * brightness;
            prod_g_reg   <= pix[15:8]  * brightness;
            prod_b_reg   <= pix[7:0]   * brightness;
            out_pos_reg  <= s2_pos_reg;
            out_last_reg <= s2_last_reg;
            out_word_reg <= {lps_pkg::div255(prod_r_reg),
                             lps_pkg::div255(prod_g_reg),
                             lps_pkg::div255(prod_b_reg)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg   <= '0;
            walking_reg   <= 1'b0;
            cursor_reg    <= '0;
            rd_ok_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[pop_cmd.idx] <= 1'b1;
            end
            // start a walk over the chain
            if (take && (pop_cmd.op == lps_pkg::ACT_SHOW))
            begin
                walking_reg <= 1'b1;
                cursor_reg  <= '0;
            end
            else if (issue)
            begin
                cursor_reg <= cursor_reg + lps_pkg::IDX_W'(1);
                if (cursor_last)
                begin
                    walking_reg <= 1'b0;
                    cursor_reg  <= '0;
                end
            end
            if (adv)
            begin
                rd_ok_reg     <= written_reg[cursor_reg];
                s1_valid_reg  <= issue;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    assign pixel_out.valid          = out_valid_reg;
    assign pixel_out.color_word     = out_word_reg;
    assign pixel_out.pixel_position = out_pos_reg;
    assign pixel_out.last_pixel     = out_last_reg;

endmodule

/* bench/tb_led_pixel_store_with_brightness_unit.sv */
module tb_led_pixel_store_with_brightness_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lps_pkg::*;

    // Give the back end this many cycles to finish queued writes once the
    // last show word has arrived.
    localparam int DRAIN_CYCLES   = 16;
    // Cycles with no handshake on any port before the run is called hung.
    localparam int WATCHDOG_LIMIT = 3000;
    // Random items sent after the directed table.
    localparam int RANDOM_ITEMS   = 290;

    typedef enum logic
    {
        STEP_ITEM = 1'b0,
        STEP_REG  = 1'b1
    } step_kind_t;

    // One row of the directed table: either an item on pixel_in or a
    // register write. known_word, when set, overrides the predicted color
    // of every word of a show.
    typedef struct packed
    {
        step_kind_t          kind;
        action_t             op;
        logic [7:0]          idx;
        logic [WORD_W-1:0]   rgb;
        logic                reg_sel;
        logic [PDATA_W-1:0]  reg_value;
        logic                known;
        logic [WORD_W-1:0]   known_word;
    } step_t;

    typedef struct packed
    {
        logic [WORD_W-1:0]   word;
        logic [IDX_W-1:0]    pos;
        logic                last;
    } shown_pixel_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    lps_in_if  pixel_in_ch ();
    lps_out_if pixel_out_ch ();

    led_pixel_store_with_brightness_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pixel_in  (pixel_in_ch),
        .pixel_out (pixel_out_ch)
    );

    // Shadow of the block: registers and the unscaled pixel store.
    logic [CH_W-1:0]     brightness_shadow;
    logic [COUNT_W-1:0]  led_count_shadow;
    logic [WORD_W-1:0]   pixel_mirror [MAX_LEDS];

    // Show words still owed by the block, oldest first.
    shown_pixel_t        shown_pixels_due [$];

    int                  errors;
    int                  quiet_cycles;
    // Set for phases that run with no idling on either side.
    logic                calm;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int live_leds();
        return (int'(led_count_shadow) > MAX_LEDS) ? MAX_LEDS : int'(led_count_shadow);
    endfunction

    // floor(c * brightness / 255)
    function automatic logic [CH_W-1:0] dim_channel(input logic [CH_W-1:0] c);
        return CH_W'((PROD_W'(c) * PROD_W'(brightness_shadow)) / PROD_W'(255));
    endfunction

    // Apply one accepted item to the shadow store; for a show, queue one
    // word per live LED, scaled with the brightness in force now.
    task automatic predict_pixel_item(input action_t op, input logic [7:0] idx,
                                      input logic [WORD_W-1:0] rgb, input logic known,
                                      input logic [WORD_W-1:0] known_word);
        int           live;
        shown_pixel_t px;
        live = live_leds();
        if (op == ACT_WRITE)
        begin
            // Drop writes past the live end of the chain.
            if (int'(idx) < live)
                pixel_mirror[idx[IDX_W-1:0]] = rgb;
        end
        else
        begin
            for (int i = 0; i < live; i++)
            begin
                px.word = {dim_channel(pixel_mirror[i][23:16]),
                           dim_channel(pixel_mirror[i][15:8]),
                           dim_channel(pixel_mirror[i][7:0])};
                if (known)
                    px.word = known_word;
                px.pos  = IDX_W'(i);
                px.last = (i + 1 == live);
                shown_pixels_due.push_back(px);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking: compare each accepted word with the oldest one owed
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        shown_pixel_t want;
        if (rst_n && pixel_out_ch.valid && pixel_out_ch.ready)
        begin
            if (shown_pixels_due.size() == 0)
            begin
                $display("%0t: unexpected word color=%06h pos=%0d last=%0b", $time,
                         pixel_out_ch.color_word, pixel_out_ch.pixel_position,
                         pixel_out_ch.last_pixel);
                errors++;
            end
            else
            begin
                want = shown_pixels_due.pop_front();
                if (pixel_out_ch.color_word !== want.word)
                begin
                    $display("%0t: color_word expected %06h actual %06h (pos %0d)", $time,
                             want.word, pixel_out_ch.color_word, want.pos);
                    errors++;
                end
                if (pixel_out_ch.pixel_position !== want.pos)
                begin
                    $display("%0t: pixel_position expected %0d actual %0d", $time,
                             want.pos, pixel_out_ch.pixel_position);
                    errors++;
                end
                if (pixel_out_ch.last_pixel !== want.last)
                begin
                    $display("%0t: last_pixel expected %0b actual %0b (pos %0d)", $time,
                             want.last, pixel_out_ch.last_pixel, want.pos);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles in which no port moves anything
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if ((pixel_in_ch.valid && pixel_in_ch.ready) ||
            (pixel_out_ch.valid && pixel_out_ch.ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no handshake for %0d cycles, %0d words owed", $time,
                     WATCHDOG_LIMIT, shown_pixels_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Idling: mostly short gaps, a few long ones, none in a calm phase
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CH_W-1:0] pick_channel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return CH_W'($urandom);
    endfunction

    // Receiver: hold ready low for a random stall now and then.
    initial
    begin
        int stall_left;
        stall_left = 0;
        pixel_out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                pixel_out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                pixel_out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender and register access
    // ------------------------------------------------------------------

    // Drive one item, wait for the handshake, predict, then idle at random.
    // Valid stays high across back-to-back items.
    task automatic send_pixel_item(input action_t op, input logic [7:0] idx,
                                   input logic [WORD_W-1:0] rgb, input logic known,
                                   input logic [WORD_W-1:0] known_word);
        int gap;
        @(negedge clk);
        pixel_in_ch.action      <= op;
        pixel_in_ch.pixel_index <= idx;
        pixel_in_ch.red         <= rgb[23:16];
        pixel_in_ch.green       <= rgb[15:8];
        pixel_in_ch.blue        <= rgb[7:0];
        pixel_in_ch.valid       <= 1'b1;
        do
            @(posedge clk);
        while (!pixel_in_ch.ready);
        predict_pixel_item(op, idx, rgb, known, known_word);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            pixel_in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop valid, wait for every owed word, then let queued writes drain.
    task automatic settle_block();
        @(negedge clk);
        pixel_in_ch.valid <= 1'b0;
        while (shown_pixels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic sel, input logic [PDATA_W-1:0] data,
                              output logic [PDATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'({sel, 2'b00});
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Read a register back and compare it with the shadow.
    task automatic check_reg(input logic sel);
        logic [PDATA_W-1:0] got;
        logic [PDATA_W-1:0] want;
        apb_access(1'b0, sel, '0, got);
        case (sel)
            REG_BRIGHTNESS: want = PDATA_W'(brightness_shadow);
            default:        want = PDATA_W'(led_count_shadow);
        endcase
        if (got !== want)
        begin
            $display("%0t: register %0d read expected %0h actual %0h", $time, sel, want, got);
            errors++;
        end
    endtask

    task automatic set_reg(input logic sel, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] unused;
        settle_block();
        apb_access(1'b1, sel, value, unused);
        case (sel)
            REG_BRIGHTNESS: brightness_shadow = value[CH_W-1:0];
            default:        led_count_shadow  = value[COUNT_W-1:0];
        endcase
        check_reg(sel);
    endtask

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------

    function automatic step_t write_step(input logic [7:0] idx, input logic [WORD_W-1:0] rgb);
        step_t s;
        s      = '0;
        s.kind = STEP_ITEM;
        s.op   = ACT_WRITE;
        s.idx  = idx;
        s.rgb  = rgb;
        return s;
    endfunction

    function automatic step_t show_step(input logic [7:0] idx, input logic [WORD_W-1:0] rgb);
        step_t s;
        s      = '0;
        s.kind = STEP_ITEM;
        s.op   = ACT_SHOW;
        s.idx  = idx;
        s.rgb  = rgb;
        return s;
    endfunction

    function automatic step_t show_known(input logic [WORD_W-1:0] word);
        step_t s;
        s            = show_step(8'd0, '0);
        s.known      = 1'b1;
        s.known_word = word;
        return s;
    endfunction

    function automatic step_t reg_step(input logic sel, input logic [PDATA_W-1:0] value);
        step_t s;
        s           = '0;
        s.kind      = STEP_REG;
        s.op        = ACT_WRITE;
        s.reg_sel   = sel;
        s.reg_value = value;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        step_t              plan [$];
        action_t            op;
        logic [7:0]         idx;
        logic [WORD_W-1:0]  rgb;
        int                 counted;
        int                 live;
        int                 n;
        int                 r;

        errors       = 0;
        quiet_cycles = 0;
        calm         = 1'b0;
        counted      = 0;

        // Hold every input at a known value from time zero.
        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        pixel_in_ch.valid       = 1'b0;
        pixel_in_ch.action      = ACT_WRITE;
        pixel_in_ch.pixel_index = '0;
        pixel_in_ch.red         = '0;
        pixel_in_ch.green       = '0;
        pixel_in_ch.blue        = '0;

        brightness_shadow = BRIGHTNESS_RESET;
        led_count_shadow  = LED_COUNT_RESET;
        foreach (pixel_mirror[i])
            pixel_mirror[i] = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Registers must read back their reset values.
        check_reg(REG_BRIGHTNESS);
        check_reg(REG_LED_COUNT);

        // Directed part.
        // A freshly reset store shows all black on all 64 LEDs.
        plan.push_back(show_known(24'h000000));
        // Both ends of the chain, then writes past the end that must drop.
        plan.push_back(write_step(8'd0,   24'hffffff));
        plan.push_back(write_step(8'd63,  24'h008001));
        plan.push_back(write_step(8'd64,  24'haa55aa));
        plan.push_back(write_step(8'd255, 24'h123456));
        plan.push_back(show_step(8'd0, '0));
        // Zero brightness blanks every word.
        plan.push_back(reg_step(REG_BRIGHTNESS, 32'd0));
        plan.push_back(show_known(24'h000000));
        // Half brightness exercises the divide by 255.
        plan.push_back(reg_step(REG_BRIGHTNESS, 32'd128));
        plan.push_back(write_step(8'd1, 24'h7f80ff));
        plan.push_back(show_step(8'd0, '0));
        // Single-LED chain: index 1 is out of range, the one word is last.
        plan.push_back(reg_step(REG_LED_COUNT, 32'd1));
        plan.push_back(write_step(8'd1, 24'hffffff));
        plan.push_back(write_step(8'd0, 24'h123456));
        plan.push_back(show_step(8'd0, '0));
        // Empty chain: writes drop and a show produces nothing.
        plan.push_back(reg_step(REG_LED_COUNT, 32'd0));
        plan.push_back(write_step(8'd0, 24'hffffff));
        plan.push_back(show_step(8'd0, '0));
        // Count above the bound saturates to 64; entries hidden by the
        // shrink come back untouched.
        plan.push_back(reg_step(REG_LED_COUNT, 32'd127));
        plan.push_back(show_step(8'd0, '0));
        // A show ignores its index and color fields.
        plan.push_back(reg_step(REG_LED_COUNT, 32'd3));
        plan.push_back(show_step(8'd200, 24'hffffff));
        // Lowest nonzero brightness floors almost everything to zero.
        plan.push_back(reg_step(REG_BRIGHTNESS, 32'd1));
        plan.push_back(write_step(8'd2, 24'hfffe01));
        plan.push_back(show_step(8'd0, '0));
        plan.push_back(reg_step(REG_BRIGHTNESS, 32'd255));
        plan.push_back(reg_step(REG_LED_COUNT, 32'd64));
        plan.push_back(show_step(8'd0, '0));

        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_REG)
                set_reg(plan[i].reg_sel, plan[i].reg_value);
            else
                send_pixel_item(plan[i].op, plan[i].idx, plan[i].rgb, plan[i].known,
                                plan[i].known_word);
        end

        // Random part: phases of one register setting each, mostly short
        // chains so shows stay cheap, with a full or saturated chain now
        // and then. Mostly in-range writes with occasional shows, plus
        // some writes aimed anywhere in the index range.
        while (counted < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);

            r = $urandom_range(0, 9);
            if (r == 0)
                set_reg(REG_BRIGHTNESS, 32'd0);
            else if (r == 1)
                set_reg(REG_BRIGHTNESS, 32'd255);
            else
                set_reg(REG_BRIGHTNESS, PDATA_W'($urandom_range(0, 255)));

            r = $urandom_range(0, 11);
            if (r == 0)
                set_reg(REG_LED_COUNT, 32'd0);
            else if (r == 1)
                set_reg(REG_LED_COUNT, PDATA_W'($urandom_range(65, 127)));
            else if (r == 2)
                set_reg(REG_LED_COUNT, 32'd64);
            else if (r == 3)
                set_reg(REG_LED_COUNT, 32'd1);
            else
                set_reg(REG_LED_COUNT, PDATA_W'($urandom_range(2, 12)));

            live = live_leds();
            n    = $urandom_range(10, 30);
            repeat (n)
            begin
                r   = $urandom_range(0, 99);
                rgb = {pick_channel(), pick_channel(), pick_channel()};
                if (r < 22)
                begin
                    op  = ACT_SHOW;
                    idx = 8'($urandom);
                end
                else
                begin
                    op = ACT_WRITE;
                    if (live > 0 && r < 88)
                        idx = 8'($urandom_range(0, live - 1));
                    else
                        idx = 8'($urandom_range(0, 255));
                end
                counted++;
                send_pixel_item(op, idx, rgb, 1'b0, '0);
            end
        end

        calm = 1'b0;
        settle_block();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/lps_pkg.sv
rtl/core/lps_in_if.sv
rtl/core/lps_out_if.sv
rtl/core/lps_queue.sv
rtl/core/lps_front.sv
rtl/core/lps_back.sv
rtl/core/led_pixel_store_with_brightness_unit.sv
bench/tb_led_pixel_store_with_brightness_unit.sv
